### rtl/v3a_pkg.sv
// Shared types, opcodes, latencies and saturation helper for the vec3 vector ALU.
`default_nettype none
package v3a_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned SAT_W         = 70;

  localparam int unsigned FRONT_LAT = 6;
  localparam int unsigned SQRT_LAT  = 32;
  localparam int unsigned DIV_LAT   = 34;
  localparam int unsigned TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  localparam logic signed [SAT_W-1:0] SAT_HI = 70'sh7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 70'sd1;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_SUB     = 5'd1,
    OP_MUL     = 5'd2,
    OP_SCALE   = 5'd3,
    OP_DIV     = 5'd4,
    OP_NEG     = 5'd5,
    OP_DOT     = 5'd6,
    OP_CROSS   = 5'd7,
    OP_LENSQ   = 5'd8,
    OP_LEN     = 5'd9,
    OP_NORM    = 5'd10,
    OP_DISTSQ  = 5'd11,
    OP_DIST    = 5'd12,
    OP_LERP    = 5'd13,
    OP_REFLECT = 5'd14,
    OP_MIN     = 5'd15,
    OP_MAX     = 5'd16
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } satw_t;

  // front end result handed to the square root / divider back end
  typedef struct packed {
    logic        vld;
    op_t         op;
    vec_t        a;
    word_t       s;
    vec_t        rv;
    logic        sat;
    logic [63:0] sq;
  } front_t;

  function automatic satw_t sat32(input logic signed [SAT_W-1:0] v);
    satw_t r;
    r.sat = 1'b1;
    if (v > SAT_HI) begin
      r.val = WORD_MAX;
    end else if (v < SAT_LO) begin
      r.val = WORD_MIN;
    end else begin
      r.val = v[WORD_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/v3a_front.sv
// Operand select, product stage, sums with floor rounding and reflect multiply.
`default_nettype none
module v3a_front #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  v3a_pkg::op_t      in_op,
  input  v3a_pkg::word_t    in_a [3],
  input  v3a_pkg::word_t    in_b [3],
  input  v3a_pkg::word_t    in_s,
  output v3a_pkg::front_t   fr_o
);

  // stage 1: input register
  logic           s1_vld_r;
  v3a_pkg::op_t   s1_op_r;
  v3a_pkg::word_t s1_a_r [3];
  v3a_pkg::word_t s1_b_r [3];
  v3a_pkg::word_t s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_op_r <= in_op;
    s1_a_r  <= in_a;
    s1_b_r  <= in_b;
    s1_s_r  <= in_s;
  end

  // stage 2: simple ops and multiplier operand select
  v3a_pkg::satw_t add_c [3];
  v3a_pkg::satw_t sub_c [3];
  v3a_pkg::satw_t neg_c [3];

  v3a_pkg::word_t    s2_rv_nxt [3];
  logic              s2_sat_nxt;
  logic signed [32:0] mx_nxt [6];
  logic signed [32:0] my_nxt [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_c[i] = v3a_pkg::sat32(70'(s1_a_r[i]) + 70'(s1_b_r[i]));
      sub_c[i] = v3a_pkg::sat32(70'(s1_a_r[i]) - 70'(s1_b_r[i]));
      neg_c[i] = v3a_pkg::sat32(-70'(s1_a_r[i]));
    end
  end

  always_comb begin
    s2_sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s2_rv_nxt[i] = '0;
    end
    for (int k = 0; k < 6; k++) begin
      mx_nxt[k] = '0;
      my_nxt[k] = '0;
    end
    case (s1_op_r)
      v3a_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          s2_rv_nxt[i] = add_c[i].val;
          s2_sat_nxt   = s2_sat_nxt | add_c[i].sat;
        end
      end
      v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          s2_rv_nxt[i] = sub_c[i].val;
          s2_sat_nxt   = s2_sat_nxt | sub_c[i].sat;
        end
      end
      v3a_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          s2_rv_nxt[i] = neg_c[i].val;
          s2_sat_nxt   = s2_sat_nxt | neg_c[i].sat;
        end
      end
      v3a_pkg::OP_MIN: begin
        for (int i = 0; i < 3; i++) begin
          s2_rv_nxt[i] = (s1_a_r[i] < s1_b_r[i]) ? s1_a_r[i] : s1_b_r[i];
        end
      end
      v3a_pkg::OP_MAX: begin
        for (int i = 0; i < 3; i++) begin
          s2_rv_nxt[i] = (s1_a_r[i] > s1_b_r[i]) ? s1_a_r[i] : s1_b_r[i];
        end
      end
      v3a_pkg::OP_MUL, v3a_pkg::OP_DOT, v3a_pkg::OP_REFLECT: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = 33'(s1_a_r[i]);
          my_nxt[i] = 33'(s1_b_r[i]);
        end
      end
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = 33'(s1_a_r[i]);
          my_nxt[i] = 33'(s1_s_r);
        end
      end
      v3a_pkg::OP_LERP: begin
        // s*(b-a) is the exact s*b - s*a
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = 33'(s1_s_r);
          my_nxt[i] = 33'(s1_b_r[i]) - 33'(s1_a_r[i]);
        end
      end
      v3a_pkg::OP_CROSS: begin
        mx_nxt[0] = 33'(s1_a_r[1]); my_nxt[0] = 33'(s1_b_r[2]);
        mx_nxt[3] = 33'(s1_a_r[2]); my_nxt[3] = 33'(s1_b_r[1]);
        mx_nxt[1] = 33'(s1_a_r[2]); my_nxt[1] = 33'(s1_b_r[0]);
        mx_nxt[4] = 33'(s1_a_r[0]); my_nxt[4] = 33'(s1_b_r[2]);
        mx_nxt[2] = 33'(s1_a_r[0]); my_nxt[2] = 33'(s1_b_r[1]);
        mx_nxt[5] = 33'(s1_a_r[1]); my_nxt[5] = 33'(s1_b_r[0]);
      end
      v3a_pkg::OP_LENSQ, v3a_pkg::OP_LEN, v3a_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = 33'(s1_a_r[i]);
          my_nxt[i] = 33'(s1_a_r[i]);
        end
      end
      v3a_pkg::OP_DISTSQ, v3a_pkg::OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = 33'(sub_c[i].val);
          my_nxt[i] = 33'(sub_c[i].val);
          s2_sat_nxt = s2_sat_nxt | sub_c[i].sat;
        end
      end
      default: ;
    endcase
  end

  logic               s2_vld_r;
  v3a_pkg::op_t       s2_op_r;
  v3a_pkg::word_t     s2_a_r [3];
  v3a_pkg::word_t     s2_b_r [3];
  v3a_pkg::word_t     s2_s_r;
  v3a_pkg::word_t     s2_rv_r [3];
  logic               s2_sat_r;
  logic signed [32:0] s2_mx_r [6];
  logic signed [32:0] s2_my_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_op_r  <= s1_op_r;
    s2_a_r   <= s1_a_r;
    s2_b_r   <= s1_b_r;
    s2_s_r   <= s1_s_r;
    s2_rv_r  <= s2_rv_nxt;
    s2_sat_r <= s2_sat_nxt;
    s2_mx_r  <= mx_nxt;
    s2_my_r  <= my_nxt;
  end

  // stage 3: six products
  logic               s3_vld_r;
  v3a_pkg::op_t       s3_op_r;
  v3a_pkg::word_t     s3_a_r [3];
  v3a_pkg::word_t     s3_b_r [3];
  v3a_pkg::word_t     s3_s_r;
  v3a_pkg::word_t     s3_rv_r [3];
  logic               s3_sat_r;
  logic signed [65:0] s3_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_op_r  <= s2_op_r;
    s3_a_r   <= s2_a_r;
    s3_b_r   <= s2_b_r;
    s3_s_r   <= s2_s_r;
    s3_rv_r  <= s2_rv_r;
    s3_sat_r <= s2_sat_r;
    for (int k = 0; k < 6; k++) begin
      s3_p_r[k] <= 66'(s2_mx_r[k]) * 66'(s2_my_r[k]);
    end
  end

  // stage 4: sums, floor to fixed point, clamp
  logic signed [67:0] dsum_c;
  logic [63:0]        sq_c;
  v3a_pkg::satw_t     dt_c;
  v3a_pkg::satw_t     lsq_c;
  v3a_pkg::satw_t     shf_c [3];
  v3a_pkg::satw_t     lrp_c [3];
  v3a_pkg::satw_t     crs_c [3];
  v3a_pkg::word_t     s4_rv_nxt [3];
  logic               s4_sat_nxt;

  assign dsum_c = 68'(s3_p_r[0]) + 68'(s3_p_r[1]) + 68'(s3_p_r[2]);
  assign sq_c   = dsum_c[63:0];
  assign dt_c   = v3a_pkg::sat32(70'(dsum_c >>> FRAC_BITS));
  assign lsq_c  = v3a_pkg::sat32(70'(sq_c >> FRAC_BITS));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shf_c[i] = v3a_pkg::sat32(70'(s3_p_r[i] >>> FRAC_BITS));
      lrp_c[i] = v3a_pkg::sat32(70'(s3_p_r[i] >>> FRAC_BITS) + 70'(s3_a_r[i]));
      crs_c[i] = v3a_pkg::sat32(70'((68'(s3_p_r[i]) - 68'(s3_p_r[i+3])) >>> FRAC_BITS));
    end
  end

  always_comb begin
    s4_rv_nxt  = s3_rv_r;
    s4_sat_nxt = s3_sat_r;
    case (s3_op_r)
      v3a_pkg::OP_MUL, v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          s4_rv_nxt[i] = shf_c[i].val;
          s4_sat_nxt   = s4_sat_nxt | shf_c[i].sat;
        end
      end
      v3a_pkg::OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          s4_rv_nxt[i] = lrp_c[i].val;
          s4_sat_nxt   = s4_sat_nxt | lrp_c[i].sat;
        end
      end
      v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          s4_rv_nxt[i] = crs_c[i].val;
          s4_sat_nxt   = s4_sat_nxt | crs_c[i].sat;
        end
      end
      v3a_pkg::OP_DOT: begin
        s4_rv_nxt[0] = dt_c.val;
        s4_sat_nxt   = dt_c.sat;
      end
      v3a_pkg::OP_REFLECT: begin
        s4_sat_nxt = dt_c.sat;
      end
      v3a_pkg::OP_LENSQ, v3a_pkg::OP_DISTSQ: begin
        s4_rv_nxt[0] = lsq_c.val;
        s4_sat_nxt   = s4_sat_nxt | lsq_c.sat;
      end
      default: ;
    endcase
  end

  logic           s4_vld_r;
  v3a_pkg::op_t   s4_op_r;
  v3a_pkg::word_t s4_a_r [3];
  v3a_pkg::word_t s4_b_r [3];
  v3a_pkg::word_t s4_s_r;
  v3a_pkg::word_t s4_rv_r [3];
  logic           s4_sat_r;
  logic [63:0]    s4_sq_r;
  v3a_pkg::word_t s4_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_op_r  <= s3_op_r;
    s4_a_r   <= s3_a_r;
    s4_b_r   <= s3_b_r;
    s4_s_r   <= s3_s_r;
    s4_rv_r  <= s4_rv_nxt;
    s4_sat_r <= s4_sat_nxt;
    s4_sq_r  <= sq_c;
    s4_dt_r  <= dt_c.val;
  end

  // stage 5: clamped dot times b for reflect
  logic               s5_vld_r;
  v3a_pkg::op_t       s5_op_r;
  v3a_pkg::word_t     s5_a_r [3];
  v3a_pkg::word_t     s5_s_r;
  v3a_pkg::word_t     s5_rv_r [3];
  logic               s5_sat_r;
  logic [63:0]        s5_sq_r;
  logic signed [63:0] s5_q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_op_r  <= s4_op_r;
    s5_a_r   <= s4_a_r;
    s5_s_r   <= s4_s_r;
    s5_rv_r  <= s4_rv_r;
    s5_sat_r <= s4_sat_r;
    s5_sq_r  <= s4_sq_r;
    for (int i = 0; i < 3; i++) begin
      s5_q_r[i] <= 64'(s4_dt_r) * 64'(s4_b_r[i]);
    end
  end

  // stage 6: a + floor(-2*dt*b)
  logic signed [65:0] m2_c  [3];
  v3a_pkg::satw_t     rfl_c [3];
  v3a_pkg::front_t    fr_nxt;
  v3a_pkg::front_t    fr_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2_c[i]  = -(66'(s5_q_r[i]) <<< 1);
      rfl_c[i] = v3a_pkg::sat32(70'(s5_a_r[i]) + 70'(m2_c[i] >>> FRAC_BITS));
    end
  end

  always_comb begin
    fr_nxt.vld  = s5_vld_r;
    fr_nxt.op   = s5_op_r;
    fr_nxt.a.x  = s5_a_r[0];
    fr_nxt.a.y  = s5_a_r[1];
    fr_nxt.a.z  = s5_a_r[2];
    fr_nxt.s    = s5_s_r;
    fr_nxt.rv.x = s5_rv_r[0];
    fr_nxt.rv.y = s5_rv_r[1];
    fr_nxt.rv.z = s5_rv_r[2];
    fr_nxt.sat  = s5_sat_r;
    fr_nxt.sq   = s5_sq_r;
    if (s5_op_r == v3a_pkg::OP_REFLECT) begin
      fr_nxt.rv.x = rfl_c[0].val;
      fr_nxt.rv.y = rfl_c[1].val;
      fr_nxt.rv.z = rfl_c[2].val;
      fr_nxt.sat  = s5_sat_r | rfl_c[0].sat | rfl_c[1].sat | rfl_c[2].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r <= '0;
    end else begin
      fr_r <= fr_nxt;
    end
  end

  assign fr_o = fr_r;

endmodule
`default_nettype wire

### rtl/v3a_sqrt.sv
// Pipelined 64-bit integer square root, one root bit per stage.
`default_nettype none
module v3a_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] in_rad,
  output logic        out_vld,
  output logic [31:0] out_root
);

  localparam int unsigned N = v3a_pkg::SQRT_LAT;

  logic        vld_r  [N];
  logic [34:0] rem_r  [N];
  logic [31:0] root_r [N];
  logic [63:0] rad_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic        vld_i;
    logic [34:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] rad_i;
    logic [34:0] sh_c;
    logic [34:0] tr_c;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign sh_c = {rem_i[32:0], rad_i[63:62]};
    assign tr_c = {1'b0, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      if (sh_c >= tr_c) begin
        rem_r[k]  <= sh_c - tr_c;
        root_r[k] <= {root_i[30:0], 1'b1};
      end else begin
        rem_r[k]  <= sh_c;
        root_r[k] <= {root_i[30:0], 1'b0};
      end
      rad_r[k] <= {rad_i[61:0], 2'b00};
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];

endmodule
`default_nettype wire

### rtl/v3a_div.sv
// Pipelined signed divide of (num << FRAC_BITS) by den, truncating, clamped to 32 bits.
`default_nettype none
module v3a_div #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  v3a_pkg::word_t     in_num,
  input  logic signed [32:0] in_den,
  output logic               out_vld,
  output v3a_pkg::word_t     out_q,
  output logic               out_sat
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned N  = 32;

  logic [31:0]     nabs_c;
  logic [NW-1:0]   nmag_c;
  logic [32:0]     dabs_c;
  logic [32:0]     hi_c;

  assign nabs_c = in_num[31] ? (~in_num + 32'd1) : in_num;
  assign nmag_c = NW'(nabs_c) << FRAC_BITS;
  assign dabs_c = in_den[32] ? (~in_den + 33'd1) : in_den;
  assign hi_c   = 33'(nmag_c[NW-1:32]);

  // setup: a quotient of 2^32 or more is flagged, and the result is clamped at the output
  logic        st_vld_r;
  logic        st_neg_r;
  logic        st_ovf_r;
  logic [32:0] st_d_r;
  logic [32:0] st_rem_r;
  logic [31:0] st_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else begin
      st_vld_r <= in_vld;
    end
    st_neg_r <= in_num[31] ^ in_den[32];
    st_ovf_r <= (hi_c >= dabs_c);
    st_d_r   <= dabs_c;
    st_rem_r <= hi_c;
    st_low_r <= nmag_c[31:0];
  end

  logic        vld_r [N];
  logic        neg_r [N];
  logic        ovf_r [N];
  logic [32:0] d_r   [N];
  logic [32:0] rem_r [N];
  logic [31:0] low_r [N];
  logic [31:0] q_r   [N];

  for (genvar j = 0; j < N; j++) begin : g_stg
    logic        vld_i;
    logic        neg_i;
    logic        ovf_i;
    logic [32:0] d_i;
    logic [32:0] rem_i;
    logic [31:0] low_i;
    logic [31:0] q_i;
    logic [33:0] sh_c;
    logic [33:0] df_c;

    if (j == 0) begin : g_first
      assign vld_i = st_vld_r;
      assign neg_i = st_neg_r;
      assign ovf_i = st_ovf_r;
      assign d_i   = st_d_r;
      assign rem_i = st_rem_r;
      assign low_i = st_low_r;
      assign q_i   = '0;
    end else begin : g_next
      assign vld_i = vld_r[j-1];
      assign neg_i = neg_r[j-1];
      assign ovf_i = ovf_r[j-1];
      assign d_i   = d_r[j-1];
      assign rem_i = rem_r[j-1];
      assign low_i = low_r[j-1];
      assign q_i   = q_r[j-1];
    end

    assign sh_c = {rem_i, low_i[31]};
    assign df_c = sh_c - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_i;
      end
      neg_r[j] <= neg_i;
      ovf_r[j] <= ovf_i;
      d_r[j]   <= d_i;
      low_r[j] <= {low_i[30:0], 1'b0};
      if (sh_c >= {1'b0, d_i}) begin
        rem_r[j] <= df_c[32:0];
        q_r[j]   <= {q_i[30:0], 1'b1};
      end else begin
        rem_r[j] <= sh_c[32:0];
        q_r[j]   <= {q_i[30:0], 1'b0};
      end
    end
  end

  // apply sign, clamp
  logic [31:0]    qm_c;
  v3a_pkg::word_t q_nxt;
  logic           sat_nxt;

  assign qm_c = q_r[N-1];

  always_comb begin
    q_nxt   = qm_c;
    sat_nxt = 1'b0;
    if (ovf_r[N-1]) begin
      sat_nxt = 1'b1;
      q_nxt   = neg_r[N-1] ? v3a_pkg::WORD_MIN : v3a_pkg::WORD_MAX;
    end else if (neg_r[N-1]) begin
      if (qm_c > 32'h8000_0000) begin
        sat_nxt = 1'b1;
        q_nxt   = v3a_pkg::WORD_MIN;
      end else begin
        q_nxt = ~qm_c + 32'd1;
      end
    end else if (qm_c[31]) begin
      sat_nxt = 1'b1;
      q_nxt   = v3a_pkg::WORD_MAX;
    end
  end

  logic           out_vld_r;
  v3a_pkg::word_t out_q_r;
  logic           out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[N-1];
    end
    out_q_r   <= q_nxt;
    out_sat_r <= sat_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_q   = out_q_r;
  assign out_sat = out_sat_r;

endmodule
`default_nettype wire

### rtl/vec3_vector_alu.sv
// Three-component Q16.16 vector ALU: top level with square root and divide back end.
// Takes one request per clock (start while busy is low; busy is high only during and
// right after reset) and returns the results in order, each as a one-cycle out_strobe
// pulse that the receiver cannot hold off. Each request passes through the six-stage
// multiply front end, the 32-stage square root and the 34-stage divider plus the output
// register; every opcode takes the same path.
// tiny_length_squared is written through cfg_valid/cfg_data and is always ready.
`default_nettype none
module vec3_vector_alu #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_kind,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_scalar,
  output logic        out_strobe,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    logic         vld;
    v3a_pkg::op_t op;
    v3a_pkg::vec_t rv;
    logic         sat;
    logic [31:0]  root;
    logic         bad;
  } tail_t;

  logic        busy_r;
  logic [15:0] tiny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      tiny_r <= 16'd1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        tiny_r <= cfg_data;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  v3a_pkg::word_t ia_c [3];
  v3a_pkg::word_t ib_c [3];

  assign ia_c[0] = in_a_x;
  assign ia_c[1] = in_a_y;
  assign ia_c[2] = in_a_z;
  assign ib_c[0] = in_b_x;
  assign ib_c[1] = in_b_y;
  assign ib_c[2] = in_b_z;

  v3a_pkg::front_t fr;

  v3a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(start & ~busy_r),
    .in_op (v3a_pkg::op_t'(in_kind)),
    .in_a  (ia_c),
    .in_b  (ib_c),
    .in_s  (in_scalar),
    .fr_o  (fr)
  );

  logic        sq_vld;
  logic [31:0] root;

  v3a_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr.vld),
    .in_rad  (fr.sq),
    .out_vld (sq_vld),
    .out_root(root)
  );

  // front results ride alongside the square root
  v3a_pkg::front_t fd_r [v3a_pkg::SQRT_LAT];
  v3a_pkg::front_t g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < v3a_pkg::SQRT_LAT; k++) begin
        fd_r[k] <= '0;
      end
    end else begin
      fd_r[0] <= fr;
      for (int k = 1; k < v3a_pkg::SQRT_LAT; k++) begin
        fd_r[k] <= fd_r[k-1];
      end
    end
  end

  assign g = fd_r[v3a_pkg::SQRT_LAT-1];

  logic signed [32:0] den_c;
  logic               bad_c;
  tail_t              tl_c;

  always_comb begin
    den_c = {1'b0, root};
    bad_c = 1'b0;
    case (g.op)
      v3a_pkg::OP_DIV: begin
        den_c = 33'(g.s);
        bad_c = (g.s == '0);
      end
      v3a_pkg::OP_NORM: begin
        bad_c = ((g.sq >> FRAC_BITS) < 64'(tiny_r)) || (root == '0);
      end
      default: ;
    endcase
    tl_c.vld  = g.vld & sq_vld;
    tl_c.op   = g.op;
    tl_c.rv   = g.rv;
    tl_c.sat  = g.sat;
    tl_c.root = root;
    tl_c.bad  = bad_c;
  end

  logic           dv_vld [3];
  v3a_pkg::word_t dv_q   [3];
  logic           dv_sat [3];
  v3a_pkg::word_t num_c  [3];

  assign num_c[0] = g.a.x;
  assign num_c[1] = g.a.y;
  assign num_c[2] = g.a.z;

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (g.vld),
      .in_num (num_c[i]),
      .in_den (den_c),
      .out_vld(dv_vld[i]),
      .out_q  (dv_q[i]),
      .out_sat(dv_sat[i])
    );
  end

  tail_t td_r [v3a_pkg::DIV_LAT];
  tail_t t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < v3a_pkg::DIV_LAT; k++) begin
        td_r[k] <= '0;
      end
    end else begin
      td_r[0] <= tl_c;
      for (int k = 1; k < v3a_pkg::DIV_LAT; k++) begin
        td_r[k] <= td_r[k-1];
      end
    end
  end

  assign t = td_r[v3a_pkg::DIV_LAT-1];

  v3a_pkg::vec_t    rv_c;
  v3a_pkg::status_t st_c;
  v3a_pkg::word_t   len_c;

  assign len_c = t.root[31] ? v3a_pkg::WORD_MAX : t.root;

  always_comb begin
    rv_c = t.rv;
    st_c = t.sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
    case (t.op)
      v3a_pkg::OP_LEN, v3a_pkg::OP_DIST: begin
        rv_c   = '0;
        rv_c.x = len_c;
        st_c   = (t.sat | t.root[31]) ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
      end
      v3a_pkg::OP_DIV, v3a_pkg::OP_NORM: begin
        if (t.bad) begin
          rv_c = '0;
          st_c = v3a_pkg::ST_BAD;
        end else begin
          rv_c.x = dv_q[0];
          rv_c.y = dv_q[1];
          rv_c.z = dv_q[2];
          st_c   = (dv_sat[0] | dv_sat[1] | dv_sat[2]) ? v3a_pkg::ST_SAT
                                                        : v3a_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  logic             out_strobe_r;
  v3a_pkg::vec_t    out_rv_r;
  v3a_pkg::status_t out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= t.vld & dv_vld[0] & dv_vld[1] & dv_vld[2];
    end
    out_rv_r     <= rv_c;
    out_status_r <= st_c;
  end

  assign out_strobe = out_strobe_r;
  assign out_r_x    = out_rv_r.x;
  assign out_r_y    = out_rv_r.y;
  assign out_r_z    = out_rv_r.z;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

### rtl/v3a_chk.sv
// Port-level checks for the vec3 vector ALU, bound to the top level.
`default_nettype none
module v3a_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic signed [31:0] out_r_x,
  input logic signed [31:0] out_r_y,
  input logic signed [31:0] out_r_z,
  input logic [1:0]  out_status
);

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, v3a_pkg::TOTAL_LAT))
    else $error("result without matching request");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == v3a_pkg::ST_BAD) |->
      (out_r_x == 32'sd0 && out_r_y == 32'sd0 && out_r_z == 32'sd0))
    else $error("bad status with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == v3a_pkg::ST_OK || out_status == v3a_pkg::ST_SAT ||
                    out_status == v3a_pkg::ST_BAD))
    else $error("undefined status code");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_strobe))
    else $error("busy low or strobe high after reset");

endmodule

bind vec3_vector_alu v3a_chk u_chk (.*);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the vec3 vector ALU: random and directed requests checked per field.
module tb_top;

  localparam int FRAC = v3a_pkg::FRAC_BITS_DEF;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    v3a_pkg::word_t   x;
    v3a_pkg::word_t   y;
    v3a_pkg::word_t   z;
    v3a_pkg::status_t st;
  } vres_t;

  class result_board;
    vres_t pending[$];
    int    errors;

    function void note(vres_t e);
      pending.push_back(e);
    endfunction

    function void check(vres_t got);
      vres_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result x=%h y=%h z=%h st=%0d", got.x, got.y, got.z, got.st);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.st !== e.st) begin
        errors++;
        if (errors <= 10)
          $display("result error: exp x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                   e.x, e.y, e.z, e.st, got.x, got.y, got.z, got.st);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic [4:0]     in_kind = '0;
  v3a_pkg::word_t in_a_x = '0, in_a_y = '0, in_a_z = '0;
  v3a_pkg::word_t in_b_x = '0, in_b_y = '0, in_b_z = '0;
  v3a_pkg::word_t in_scalar = '0;
  logic           out_strobe;
  v3a_pkg::word_t out_r_x, out_r_y, out_r_z;
  logic [1:0]     out_status;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [15:0]    cfg_data = '0;

  logic [15:0] tiny_lsq = 16'd1;
  result_board board = new();

  always #5 clk = ~clk;

  vec3_vector_alu u_top (
    .clk, .rst_n, .start, .busy, .in_kind,
    .in_a_x, .in_a_y, .in_a_z, .in_b_x, .in_b_y, .in_b_z, .in_scalar,
    .out_strobe, .out_r_x, .out_r_y, .out_r_z, .out_status,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  function automatic v3a_pkg::word_t clamp(input wide_t v, inout bit sat);
    if (v > wide_t'(v3a_pkg::WORD_MAX)) begin
      sat = 1'b1;
      return v3a_pkg::WORD_MAX;
    end
    if (v < wide_t'(v3a_pkg::WORD_MIN)) begin
      sat = 1'b1;
      return v3a_pkg::WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic wide_t sq_sum(input wide_t v0, input wide_t v1, input wide_t v2);
    return v0 * v0 + v1 * v1 + v2 * v2;
  endfunction

  // expected result of one vector request
  function automatic vres_t vec_op_result(input logic [4:0] kind, input v3a_pkg::vec_t av,
                                          input v3a_pkg::vec_t bv, input v3a_pkg::word_t sc,
                                          input logic [15:0] thr);
    wide_t a[3], b[3], d[3], s, one, sq, dt, len;
    v3a_pkg::word_t r[3];
    bit sat, bad;
    vres_t res;
    a[0] = av.x; a[1] = av.y; a[2] = av.z;
    b[0] = bv.x; b[1] = bv.y; b[2] = bv.z;
    s = sc;
    one = wide_t'(1) <<< FRAC;
    sat = 0;
    bad = 0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    case (kind)
      v3a_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], sat);
      v3a_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], sat);
      v3a_pkg::OP_MUL: for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * b[i]) >>> FRAC, sat);
      v3a_pkg::OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * s) >>> FRAC, sat);
      v3a_pkg::OP_DIV: begin
        if (s == 0) bad = 1;
        else for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * one) / s, sat);
      end
      v3a_pkg::OP_NEG: for (int i = 0; i < 3; i++) r[i] = clamp(-a[i], sat);
      v3a_pkg::OP_DOT: r[0] = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC, sat);
      v3a_pkg::OP_CROSS: begin
        r[0] = clamp((a[1] * b[2] - a[2] * b[1]) >>> FRAC, sat);
        r[1] = clamp((a[2] * b[0] - a[0] * b[2]) >>> FRAC, sat);
        r[2] = clamp((a[0] * b[1] - a[1] * b[0]) >>> FRAC, sat);
      end
      v3a_pkg::OP_LENSQ: r[0] = clamp(sq_sum(a[0], a[1], a[2]) >>> FRAC, sat);
      v3a_pkg::OP_LEN: r[0] = clamp(wide_t'(floor_sqrt(sq_sum(a[0], a[1], a[2]))), sat);
      v3a_pkg::OP_NORM: begin
        sq = sq_sum(a[0], a[1], a[2]);
        len = wide_t'(floor_sqrt(sq));
        if ((sq >>> FRAC) < wide_t'(thr) || len == 0) bad = 1;
        else for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * one) / len, sat);
      end
      v3a_pkg::OP_DISTSQ, v3a_pkg::OP_DIST: begin
        for (int i = 0; i < 3; i++) d[i] = wide_t'(clamp(a[i] - b[i], sat));
        sq = sq_sum(d[0], d[1], d[2]);
        if (kind == v3a_pkg::OP_DISTSQ) r[0] = clamp(sq >>> FRAC, sat);
        else r[0] = clamp(wide_t'(floor_sqrt(sq)), sat);
      end
      v3a_pkg::OP_LERP:
        for (int i = 0; i < 3; i++) r[i] = clamp((s * b[i] - s * a[i] + a[i] * one) >>> FRAC, sat);
      v3a_pkg::OP_REFLECT: begin
        dt = wide_t'(clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC, sat));
        for (int i = 0; i < 3; i++)
          r[i] = clamp((a[i] * one - 2 * dt * b[i]) >>> FRAC, sat);
      end
      v3a_pkg::OP_MIN: for (int i = 0; i < 3; i++) r[i] = (a[i] < b[i]) ? a[i][31:0] : b[i][31:0];
      v3a_pkg::OP_MAX: for (int i = 0; i < 3; i++) r[i] = (a[i] > b[i]) ? a[i][31:0] : b[i][31:0];
      default: ;
    endcase
    if (bad) for (int i = 0; i < 3; i++) r[i] = '0;
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    res.st = bad ? v3a_pkg::ST_BAD : (sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK);
    return res;
  endfunction

  // request and result monitors, sampled at the edge before driven updates land
  always @(posedge clk) begin
    v3a_pkg::vec_t av, bv;
    vres_t got;
    if (rst_n && start && !busy) begin
      av = '{in_a_x, in_a_y, in_a_z};
      bv = '{in_b_x, in_b_y, in_b_z};
      board.note(vec_op_result(in_kind, av, bv, in_scalar, tiny_lsq));
    end
    if (rst_n && cfg_valid && cfg_ready) tiny_lsq <= cfg_data;
    if (rst_n && out_strobe) begin
      got.x = out_r_x;
      got.y = out_r_y;
      got.z = out_r_z;
      got.st = v3a_pkg::status_t'(out_status);
      board.check(got);
    end
  end

  task automatic send_req(input logic [4:0] kind, input v3a_pkg::vec_t av,
                          input v3a_pkg::vec_t bv, input v3a_pkg::word_t sc);
    start <= 1'b1;
    in_kind <= kind;
    in_a_x <= av.x; in_a_y <= av.y; in_a_z <= av.z;
    in_b_x <= bv.x; in_b_y <= bv.y; in_b_z <= bv.z;
    in_scalar <= sc;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tiny(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic v3a_pkg::word_t rand_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return $urandom;
      3, 4, 5: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      6: return $signed($urandom_range(0, 600)) - 300;
      7: begin
        case ($urandom_range(0, 4))
          0: return v3a_pkg::WORD_MAX;
          1: return v3a_pkg::WORD_MIN;
          2: return 32'sd0;
          3: return 32'sd65536;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic v3a_pkg::vec_t rand_vec();
    v3a_pkg::vec_t v;
    v.x = rand_word();
    v.y = rand_word();
    v.z = rand_word();
    return v;
  endfunction

  task automatic random_phase(input int count, input bit gaps);
    logic [4:0] kind;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) kind = 5'($urandom_range(v3a_pkg::OP_MAX + 1, 31));
      else kind = 5'($urandom_range(v3a_pkg::OP_ADD, v3a_pkg::OP_MAX));
      send_req(kind, rand_vec(), rand_vec(), rand_word());
      if (gaps) begin
        case ($urandom_range(0, 19))
          0: pause_sender($urandom_range(20, 80));
          1, 2, 3, 4, 5, 6: pause_sender($urandom_range(1, 3));
          default: ;
        endcase
      end
    end
    drain();
  endtask

  initial begin
    v3a_pkg::vec_t vmax, vmin, vzero, vunit, vtiny;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    vmax = '{v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX};
    vmin = '{v3a_pkg::WORD_MIN, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MIN};
    vzero = '{32'sd0, 32'sd0, 32'sd0};
    vunit = '{32'sd65536, -32'sd131072, 32'sd196608};
    vtiny = '{32'sd1, -32'sd1, 32'sd0};

    // directed: every opcode plus the extremes and special cases
    for (int k = v3a_pkg::OP_ADD; k <= v3a_pkg::OP_MAX; k++)
      send_req(k[4:0], vmax, vmin, v3a_pkg::WORD_MIN);
    send_req(v3a_pkg::OP_DIV, vunit, vzero, 32'sd0);
    send_req(v3a_pkg::OP_NORM, vzero, vzero, 32'sd0);
    send_req(v3a_pkg::OP_NORM, vtiny, vzero, 32'sd0);
    send_req(v3a_pkg::OP_NORM, vunit, vzero, 32'sd0);
    send_req(v3a_pkg::OP_CROSS, vunit, '{32'sd7, 32'sd65536, -32'sd3}, 32'sd0);
    send_req(v3a_pkg::OP_REFLECT, vmax, vmax, 32'sd0);
    send_req(v3a_pkg::OP_LERP, vunit, vmin, v3a_pkg::WORD_MAX);
    send_req(5'd31, vmax, vmax, v3a_pkg::WORD_MAX);
    drain();

    write_tiny(16'd0);
    random_phase(220, 1'b1);
    write_tiny(16'hFFFF);
    random_phase(220, 1'b0);
    write_tiny(16'($urandom));
    random_phase(220, 1'b1);
    write_tiny(16'd1);
    random_phase(220, 1'b1);
    write_tiny(16'($urandom_range(1, 16)));
    random_phase(220, 1'b1);
    write_tiny(16'($urandom));
    random_phase(230, 1'b1);

    repeat (v3a_pkg::TOTAL_LAT + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("vec3_vector_alu: match");
    end else begin
      $display("vec3_vector_alu: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("vec3_vector_alu: mismatch");
    $finish;
  end

endmodule
